// File: sv/rngdm_pkg.sv
// ----------------------------------------------------------------------------
// rngdm_pkg
// Shared types and constants of the rumble noise gain and delay monitor.
// ----------------------------------------------------------------------------
package rngdm_pkg;

  localparam int SampleW   = 16;
  localparam int GainW     = 8;
  localparam int CylW      = 3;
  localparam int NumCyl    = 4;
  localparam int CylIdxW   = $clog2(NumCyl);
  localparam int NumTaps   = 4;
  localparam int GainShift = 5;                     // gain numerator is diff * 32
  localparam int NumW      = SampleW + GainShift;   // dividend width, one quotient bit a cycle
  localparam int DivCntW   = $clog2(NumW);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET0 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFFSET2 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFFSET3 = 3'd5;

  // tap0 source codes
  localparam logic [1:0] MODE_PEAK  = 2'd0;
  localparam logic [1:0] MODE_MEAN  = 2'd1;
  localparam logic [1:0] MODE_GAIN  = 2'd2;
  localparam logic [1:0] MODE_KNOCK = 2'd3;

  typedef struct packed {
    logic                             enable;
    logic [1:0]                       mode;
    logic [NumCyl-1:0][SampleW-1:0]   offset;
  } cfg_t;

  // one finished event window, handed from front to back
  typedef struct packed {
    logic [SampleW-1:0]               peak;
    logic [CylW-1:0]                  cyl;
    logic                             knock;
    logic [NumCyl-1:0][SampleW-1:0]   means;
  } event_t;

endpackage

// File: sv/rngdm_front.sv
// ----------------------------------------------------------------------------
// rngdm_front
// Takes noise samples, keeps the running peak and emits one event per window.
// ----------------------------------------------------------------------------
module rngdm_front import rngdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [SampleW-1:0]   noise_sample,
  input  logic                 window_last,
  input  logic [CylW-1:0]      cylinder,
  input  logic [SampleW-1:0]   mean_in0,
  input  logic [SampleW-1:0]   mean_in1,
  input  logic [SampleW-1:0]   mean_in2,
  input  logic [SampleW-1:0]   mean_in3,
  input  logic                 knock_in,
  input  logic                 fifo_full,
  output logic                 push,
  output event_t               push_event
);

  logic [SampleW-1:0] running_peak;
  logic [SampleW-1:0] peak;
  logic               accept;

  assign sample_stall = fifo_full;
  assign accept       = sample_valid && !sample_stall;
  assign peak         = (noise_sample > running_peak) ? noise_sample : running_peak;
  assign push         = accept && window_last;

  always_comb begin
    push_event.peak     = peak;
    push_event.cyl      = cylinder;
    push_event.knock    = knock_in;
    push_event.means[0] = mean_in0;
    push_event.means[1] = mean_in1;
    push_event.means[2] = mean_in2;
    push_event.means[3] = mean_in3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
    end else if (accept) begin
      running_peak <= window_last ? '0 : peak;
    end
  end

endmodule

// File: sv/rngdm_fifo.sv
// ----------------------------------------------------------------------------
// rngdm_fifo
// Short event queue between front and back.
// ----------------------------------------------------------------------------
module rngdm_fifo import rngdm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  event_t  push_event,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output event_t  head_event
);

  event_t                mem [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr;
  logic [FifoPtrW-1:0]   rd_ptr;
  logic [FifoCntW-1:0]   count;

  assign full       = (count == FifoCntW'(FifoDepth));
  assign head_valid = (count != '0);
  assign head_event = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: sv/rngdm_back.sv
// ----------------------------------------------------------------------------
// rngdm_back
// Executes queued events: serial gain divide, state update, result register.
// ----------------------------------------------------------------------------
module rngdm_back import rngdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 head_valid,
  input  event_t               head_event,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [SampleW-1:0]   tap0,
  output logic [SampleW-1:0]   tap1,
  output logic [SampleW-1:0]   tap2,
  output logic [SampleW-1:0]   tap3,
  output logic [SampleW-1:0]   peak_out,
  output logic [SampleW-1:0]   mean_out,
  output logic [GainW-1:0]     gain_out,
  output logic                 knock_out,
  output logic                 index_error
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  // architectural state
  logic [NumCyl-1:0][SampleW-1:0]   prior_mean;
  logic [NumTaps-1:0][SampleW-1:0]  taps;
  logic [NumCyl-1:0][GainW-1:0]     cyl_gain;
  logic [SampleW-1:0]               held_peak;
  logic [SampleW-1:0]               held_mean;
  logic                             held_knock;

  // event being worked on
  event_t               work;
  logic [SampleW-1:0]   work_pmean;
  logic                 work_pos;
  logic [NumW-1:0]      num;
  logic [SampleW-1:0]   rem;
  logic [DivCntW-1:0]   cnt;

  logic [CylIdxW-1:0]   head_idx;
  logic [CylIdxW-1:0]   work_idx;
  logic [SampleW-1:0]   head_offset;
  logic [SampleW-1:0]   head_pmean;
  logic                 head_pos;
  logic                 head_cyl_ok;
  logic                 work_cyl_ok;
  logic [SampleW:0]     trial;
  logic                 trial_ge;
  logic [GainW-1:0]     gain_calc;
  logic [SampleW-1:0]   tap0_src;
  logic                 commit;
  logic                 do_div;

  assign head_idx    = head_event.cyl[CylIdxW-1:0];
  assign work_idx    = work.cyl[CylIdxW-1:0];
  assign head_cyl_ok = (head_event.cyl < CylW'(NumCyl));
  assign work_cyl_ok = (work.cyl < CylW'(NumCyl));
  assign head_offset = cfg.offset[head_idx];
  assign head_pmean  = prior_mean[head_idx];
  assign head_pos    = (head_event.peak > head_offset);
  assign do_div      = cfg.enable && head_cyl_ok && head_pos && (head_pmean != '0);

  assign pop    = (state == ST_IDLE) && head_valid;
  assign commit = (state == ST_FIN) && (!result_valid || !result_stall);

  // restoring divide step
  assign trial    = {rem, num[NumW-1]};
  assign trial_ge = (trial >= {1'b0, work_pmean});

  always_comb begin
    if (work_pmean == '0)    gain_calc = '1;
    else if (!work_pos)      gain_calc = '0;
    else if (|num[NumW-1:GainW]) gain_calc = '1;
    else                     gain_calc = num[GainW-1:0];
  end

  always_comb begin
    case (cfg.mode)
      MODE_PEAK: tap0_src = work.peak;
      MODE_MEAN: tap0_src = work_pmean;
      MODE_GAIN: tap0_src = {gain_calc, gain_calc};
      default:   tap0_src = work.knock ? '1 : '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head_valid) state_next = do_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (cnt == DivCntW'(NumW - 1)) state_next = ST_FIN;
      ST_FIN:  if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // work registers
  always_ff @(posedge clk) begin
    if (pop) begin
      work       <= head_event;
      work_pmean <= head_pmean;
      work_pos   <= head_pos;
      num        <= {SampleW'(head_event.peak - head_offset), GainShift'(0)};
      rem        <= '0;
      cnt        <= '0;
    end else if (state == ST_DIV) begin
      num <= {num[NumW-2:0], trial_ge};
      rem <= trial_ge ? SampleW'(trial - {1'b0, work_pmean}) : trial[SampleW-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_mean   <= '0;
      taps         <= '0;
      cyl_gain     <= '0;
      held_peak    <= '0;
      held_mean    <= '0;
      held_knock   <= 1'b0;
      gain_out     <= '0;
      index_error  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (commit) begin
        result_valid <= 1'b1;
        prior_mean   <= work.means;
        index_error  <= cfg.enable && !work_cyl_ok;
        if (!work_cyl_ok)    gain_out <= '0;
        else if (cfg.enable) gain_out <= gain_calc;
        else                 gain_out <= cyl_gain[work_idx];
        if (cfg.enable) begin
          taps[NumTaps-1:1] <= taps[NumTaps-2:0];
          if (work_cyl_ok) begin
            taps[0]            <= tap0_src;
            cyl_gain[work_idx] <= gain_calc;
            held_peak          <= work.peak;
            held_mean          <= work_pmean;
            held_knock         <= work.knock;
          end
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign tap0      = taps[0];
  assign tap1      = taps[1];
  assign tap2      = taps[2];
  assign tap3      = taps[3];
  assign peak_out  = held_peak;
  assign mean_out  = held_mean;
  assign knock_out = held_knock;

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside finish step");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < DivCntW'(NumW)))
    else $error("divide counter overran");

  a_error_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && index_error) |-> (gain_out == '0))
    else $error("index error with nonzero gain");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_IDLE))
    else $error("event popped but back stayed idle");

endmodule

// File: sv/rumble_noise_gain_delay_monitor.sv
// ----------------------------------------------------------------------------
// rumble_noise_gain_delay_monitor
// Per-cylinder knock noise peak, gain and four-tap bench delay channel.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  sample    sample_valid / sample_stall noise_sample, window_last, cylinder,
//                                        mean_in0..3, knock_in
//  result    result_valid / result_stall tap0..3, peak_out, mean_out, gain_out,
//                                        knock_out, index_error
//  config    cfg_write                   cfg_index, cfg_data
//
//  A sample that does not end a window is accepted while the queue has room.
//  A window's last sample queues an event; the back end then executes it,
//  through the gain divide when that runs (21 quotient bits, one per cycle).
//  Two events can wait in the queue; sample_stall rises only when it is full.
//  Synchronous active-high reset clears the configuration, control and outputs.
//  A stalled result holds, and the back end waits for it before the next.
// ----------------------------------------------------------------------------
module rumble_noise_gain_delay_monitor import rngdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // sample channel
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [SampleW-1:0]   noise_sample,
  input  logic                 window_last,
  input  logic [CylW-1:0]      cylinder,
  input  logic [SampleW-1:0]   mean_in0,
  input  logic [SampleW-1:0]   mean_in1,
  input  logic [SampleW-1:0]   mean_in2,
  input  logic [SampleW-1:0]   mean_in3,
  input  logic                 knock_in,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [SampleW-1:0]   tap0,
  output logic [SampleW-1:0]   tap1,
  output logic [SampleW-1:0]   tap2,
  output logic [SampleW-1:0]   tap3,
  output logic [SampleW-1:0]   peak_out,
  output logic [SampleW-1:0]   mean_out,
  output logic [GainW-1:0]     gain_out,
  output logic                 knock_out,
  output logic                 index_error
);

  cfg_t    cfg;
  logic    push;
  event_t  push_event;
  logic    fifo_full;
  logic    pop;
  logic    head_valid;
  event_t  head_event;

  // configuration registers; the user must write them only while the block
  // is idle, so the back end reads them directly; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE:  cfg.enable    <= cfg_data[0];
        REG_MODE:    cfg.mode      <= cfg_data[1:0];
        REG_OFFSET0: cfg.offset[0] <= cfg_data[SampleW-1:0];
        REG_OFFSET1: cfg.offset[1] <= cfg_data[SampleW-1:0];
        REG_OFFSET2: cfg.offset[2] <= cfg_data[SampleW-1:0];
        REG_OFFSET3: cfg.offset[3] <= cfg_data[SampleW-1:0];
        default: ;  // unmapped indexes are dropped
      endcase
    end
  end

  // front: running peak, one event per window
  rngdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .noise_sample (noise_sample),
    .window_last  (window_last),
    .cylinder     (cylinder),
    .mean_in0     (mean_in0),
    .mean_in1     (mean_in1),
    .mean_in2     (mean_in2),
    .mean_in3     (mean_in3),
    .knock_in     (knock_in),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_event   (push_event)
  );

  // event queue decouples sampling from the divide
  rngdm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  // back: gain divide, delay line, held values, result word
  rngdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_event   (head_event),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .tap0         (tap0),
    .tap1         (tap1),
    .tap2         (tap2),
    .tap3         (tap3),
    .peak_out     (peak_out),
    .mean_out     (mean_out),
    .gain_out     (gain_out),
    .knock_out    (knock_out),
    .index_error  (index_error)
  );

endmodule
